FILE: rtl/espc_pkg.sv
// ----------------------------------------------------------------------------
// espc_pkg
// Shared constants and a saturation function for the encoder speed PID controller.
// ----------------------------------------------------------------------------
package espc_pkg;

  localparam int COUNTS_PER_REV_DEF = 2000;
  localparam int AVERAGE_LENGTH_DEF = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FFS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FFO    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DBAND  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ILIM   = 3'd7;

  // Actions.
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S24_MIN = -24'sh800000;
  localparam logic [14:0] DUTY_MAX = 15'd25600;

  // Saturate a wide signed value to 24 bits.
  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) r = S24_MAX;
    else if (v < -64'sd8388608) r = S24_MIN;
    else r = v[23:0];
    return r;
  endfunction

endpackage

FILE: rtl/espc_divider.sv
// ----------------------------------------------------------------------------
// espc_divider
// Shared sequential divider: signed numerator by positive divisor, one
// quotient bit per cycle, result rounded to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module espc_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic        [47:0] den,
  output logic               done,
  output logic signed [63:0] quo
);
  import espc_pkg::*;

  logic [63:0] q_r, q_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [47:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  logic [63:0] mag;
  logic [48:0] trial;
  logic [63:0] qr;

  // Add half the divisor before dividing to round the magnitude.
  always_comb begin
    mag   = num[63] ? 64'(-num) : 64'(num);
    trial = {rem_r[47:0], q_r[63]};
    qr    = '0;
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt    = mag + 64'(den >> 1);
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = num[63];
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    qr = neg_r ? -q_r : q_r;
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt; neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = $signed(qr);
endmodule

FILE: rtl/encoder_speed_pid_controller.sv
// ----------------------------------------------------------------------------
// encoder_speed_pid_controller
// Encoder count accumulation and a PID speed loop with feedforward.
// ----------------------------------------------------------------------------
// Channel | Signals                                     | Direction
// input   | in_valid/in_ready, action, encoder, ms      | in
// result  | out_valid/out_ready, duty, speed, error, pid| out
// config  | cfg_we, cfg_idx, cfg_data                   | in
// Actions 0 and 1 are taken directly and can follow back to back.
// A control update closes the input from when it is taken until it is done:
// two passes through the shared sequential divider (rpm and derivative),
// a sum over the history entries (five by default), and constant scaling,
// PID accumulation and duty limiting.
// Reset is synchronous and returns the control and config registers to defaults.
// The result waits in the output register while later items are taken; an
// update that finishes while it still waits holds in its last step, and the
// input stays closed until the register is free.
module encoder_speed_pid_controller #(
  parameter int COUNTS_PER_REV = espc_pkg::COUNTS_PER_REV_DEF,
  parameter int AVERAGE_LENGTH = espc_pkg::AVERAGE_LENGTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_action,
  input  logic [15:0]                     in_encoder_count,
  input  logic [15:0]                     in_elapsed_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [6:0]                      out_duty_percent,
  output logic                            out_duty_written,
  output logic signed [23:0]              out_filtered_speed,
  output logic signed [23:0]              out_speed_error,
  output logic signed [23:0]              out_pid_output,
  input  logic                            cfg_we,
  input  logic [espc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [espc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import espc_pkg::*;

  localparam int SLOT_W = (AVERAGE_LENGTH > 1) ? $clog2(AVERAGE_LENGTH) : 1;

  // Reciprocal of the average length, scaled by 2^31 and rounded up.
  localparam logic [31:0] AVG_RECIP =
    32'(((64'd1 << 31) + 64'(AVERAGE_LENGTH) - 64'd1) / 64'(AVERAGE_LENGTH));
  localparam logic [31:0] AVG_HALF = 32'(AVERAGE_LENGTH / 2);
  // Reciprocal of 1000, scaled by 2^40 and rounded up.
  localparam logic [30:0] MS_RECIP = 31'd1099511628;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_RPM   = 10'b0000000010,
    ST_AVG   = 10'b0000000100,
    ST_SUM   = 10'b0000001000,
    ST_ERR   = 10'b0000010000,
    ST_INT   = 10'b0000100000,
    ST_DER   = 10'b0001000000,
    ST_PID   = 10'b0010000000,
    ST_FF    = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  // Configuration registers.
  logic [15:0] target_r, kp_r, ki_r, kd_r, ffs_r, ffo_r, dband_r, ilim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0; kp_r <= '0; ki_r <= '0; kd_r <= '0;
      ffs_r <= 16'd1995; ffo_r <= 16'd2936; dband_r <= 16'd256; ilim_r <= 16'd12800;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TARGET: target_r <= cfg_data;
        REG_KP:     kp_r     <= cfg_data;
        REG_KI:     ki_r     <= cfg_data;
        REG_KD:     kd_r     <= cfg_data;
        REG_FFS:    ffs_r    <= cfg_data;
        REG_FFO:    ffo_r    <= cfg_data;
        REG_DBAND:  dband_r  <= cfg_data;
        REG_ILIM:   ilim_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [15:0] enc_last_r, enc_last_nxt;
  logic signed [23:0] accum_r, accum_nxt;
  logic signed [23:0] hist_r [AVERAGE_LENGTH];
  logic [SLOT_W-1:0] slot_r, slot_nxt, sum_i_r, sum_i_nxt;
  logic signed [23:0] integ_r, integ_nxt, prev_r, prev_nxt;
  logic [14:0] held_r, held_nxt;
  logic [16:0] ms_r, ms_nxt;
  logic signed [31:0] sum_r, sum_nxt;
  logic signed [23:0] filt_r, filt_nxt, err_r, err_nxt, pid_r, pid_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic [29:0]        part_r, part_nxt;
  logic [30:0]        base_r, base_nxt;
  logic signed [35:0] deriv_r, deriv_nxt;
  logic               wr_r, wr_nxt;
  logic               hist_we;
  logic signed [23:0] hist_wd;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         dstep_r, dstep_nxt;

  logic               div_start, div_done;
  logic signed [63:0] div_num, div_quo;
  logic [47:0]        div_den;

  espc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(div_den), .done(div_done), .quo(div_quo)
  );

  // Shared gain multiplier: one PID term per step.
  logic signed [16:0] mul_a;
  logic signed [35:0] mul_b;
  logic signed [52:0] mul_p;

  assign mul_a = (dstep_r == 2'd0) ? $signed({1'b0, kp_r}) :
                 (dstep_r == 2'd1) ? $signed({1'b0, ki_r}) : $signed({1'b0, kd_r});
  assign mul_b = (dstep_r == 2'd0) ? 36'(err_r) :
                 (dstep_r == 2'd1) ? 36'(integ_r) : deriv_r;
  assign mul_p = mul_a * mul_b;

  logic signed [16:0] d16;
  logic signed [23:0] lim;
  logic signed [31:0] integ_sum;
  logic signed [24:0] err_mag;
  logic signed [31:0] duty;
  logic [31:0]        sum_mag;
  logic [59:0]        avg_prod;
  logic signed [63:0] avg_q;
  logic [23:0]        emag;
  logic [39:0]        int_prod;
  logic [60:0]        int_recip;
  logic signed [31:0] int_q;
  logic [63:0]        pid_mag, pid_q;
  logic [31:0]        ff_prod;

  // Sequencer: variable divisions go through the shared divider, constant
  // scaling uses reciprocal multiplication and shifts.
  always_comb begin
    state_nxt = state_r; enc_last_nxt = enc_last_r; accum_nxt = accum_r;
    slot_nxt = slot_r; sum_i_nxt = sum_i_r; integ_nxt = integ_r; prev_nxt = prev_r;
    held_nxt = held_r; ms_nxt = ms_r; sum_nxt = sum_r; filt_nxt = filt_r;
    err_nxt = err_r; pid_nxt = pid_r; acc_nxt = acc_r; wr_nxt = wr_r;
    part_nxt = part_r; base_nxt = base_r; deriv_nxt = deriv_r;
    out_valid_nxt = out_valid_r; dstep_nxt = dstep_r;
    hist_we = 1'b0; hist_wd = '0;
    div_start = 1'b0; div_num = '0; div_den = '0;
    d16 = $signed({1'b0, in_encoder_count - enc_last_r}) ;
    d16 = $signed({d16[15], d16[15:0]});
    lim = $signed({8'd0, ilim_r});
    integ_sum = '0; err_mag = '0; duty = '0;
    sum_mag = '0; avg_prod = '0; avg_q = '0; emag = '0; int_prod = '0;
    int_recip = '0; int_q = '0; pid_mag = '0; pid_q = '0; ff_prod = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (in_action)
            ACT_LOAD: enc_last_nxt = in_encoder_count;
            ACT_SAMPLE: begin
              enc_last_nxt = in_encoder_count;
              accum_nxt = sat24(64'(accum_r) + 64'(d16));
            end
            ACT_UPDATE: begin
              ms_nxt = (in_elapsed_ms == 16'd0) ? 17'd100 : {1'b0, in_elapsed_ms};
              state_nxt = ST_RPM;
              dstep_nxt = 2'd0;
            end
            default: ;
          endcase
        end
      end
      ST_RPM: begin
        if (dstep_r == 2'd0) begin
          div_start = 1'b1;
          div_num = 64'(accum_r) * 64'sd15360000;
          div_den = 48'(ms_r) * 48'(COUNTS_PER_REV);
          dstep_nxt = 2'd1;
        end else if (div_done) begin
          hist_we = 1'b1;
          hist_wd = sat24(div_quo);
          slot_nxt = (32'(slot_r) + 1 >= AVERAGE_LENGTH) ? '0 : slot_r + 1'b1;
          sum_nxt = '0; sum_i_nxt = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt = sum_r + 32'(hist_r[sum_i_r]);
        if (32'(sum_i_r) == AVERAGE_LENGTH - 1) begin
          state_nxt = ST_AVG; dstep_nxt = 2'd0;
        end else sum_i_nxt = sum_i_r + 1'b1;
      end
      ST_AVG: begin
        if (dstep_r == 2'd0) begin
          // Rounded magnitude of the sum.
          sum_mag = sum_r[31] ? 32'(-sum_r) : 32'(sum_r);
          acc_nxt = $signed(64'(sum_mag) + 64'(AVG_HALF));
          dstep_nxt = 2'd1;
        end else begin
          avg_prod = acc_r[27:0] * AVG_RECIP;
          avg_q = $signed(64'(avg_prod[59:31]));
          filt_nxt = sat24(sum_r[31] ? -avg_q : avg_q);
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        err_nxt = sat24(64'($signed({1'b0, target_r})) - 64'(filt_r));
        state_nxt = ST_INT; dstep_nxt = 2'd0;
      end
      ST_INT: begin
        unique case (dstep_r)
          2'd0: begin
            // Rounded magnitude of error times elapsed time.
            emag = err_r[23] ? 24'(-err_r) : 24'(err_r);
            int_prod = emag * ms_r;
            acc_nxt = $signed(64'(int_prod) + 64'd500);
            dstep_nxt = 2'd1;
          end
          2'd1: begin
            // Split at bit 20: 2^20 = 1048 * 1000 + 576.
            part_nxt = 30'(acc_r[39:20]) * 30'd576 + 30'(acc_r[19:0]);
            base_nxt = 31'(acc_r[39:20]) * 31'd1048;
            dstep_nxt = 2'd2;
          end
          2'd2: begin
            int_recip = part_r * MS_RECIP;
            acc_nxt = $signed(64'(base_r) + 64'(int_recip[60:40]));
            dstep_nxt = 2'd3;
          end
          default: begin
            int_q = err_r[23] ? -$signed(acc_r[31:0]) : $signed(acc_r[31:0]);
            integ_sum = 32'(integ_r) + int_q;
            if (integ_sum > 32'(lim)) integ_nxt = lim;
            else if (integ_sum < -32'(lim)) integ_nxt = -lim;
            else integ_nxt = integ_sum[23:0];
            state_nxt = ST_DER; dstep_nxt = 2'd0;
          end
        endcase
      end
      ST_DER: begin
        if (dstep_r == 2'd0) begin
          div_start = 1'b1;
          div_num = (64'(err_r) - 64'(prev_r)) * 64'sd1000;
          div_den = 48'(ms_r); dstep_nxt = 2'd1;
        end else if (div_done) begin
          // The derivative fits 35 bits.
          deriv_nxt = div_quo[35:0];
          state_nxt = ST_PID; dstep_nxt = 2'd0;
        end
      end
      ST_PID: begin
        unique case (dstep_r)
          2'd0: begin
            acc_nxt = 64'(mul_p);
            dstep_nxt = 2'd1;
          end
          2'd1, 2'd2: begin
            acc_nxt = acc_r + 64'(mul_p);
            dstep_nxt = dstep_r + 2'd1;
          end
          default: begin
            // Round the sum of Q8 values times Q4.12 gains back to Q8.
            pid_mag = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
            pid_q = (pid_mag + 64'd2048) >> 12;
            pid_nxt = sat24(acc_r[63] ? -$signed(pid_q) : $signed(pid_q));
            state_nxt = ST_FF; dstep_nxt = 2'd0;
          end
        endcase
      end
      ST_FF: begin
        if (dstep_r == 2'd0) begin
          ff_prod = ffs_r * target_r + 32'd2048;
          acc_nxt = $signed(64'(ff_prod[31:12]));
          dstep_nxt = 2'd1;
        end else begin
          err_mag = err_r[23] ? -25'(err_r) : 25'(err_r);
          wr_nxt = 1'b0;
          if (err_mag > $signed({9'd0, dband_r})) begin
            duty = 32'(pid_r) + $signed(acc_r[31:0]) + 32'($signed(ffo_r));
            if (target_r == 16'd0 || duty < 0) held_nxt = '0;
            else if (duty > 32'(DUTY_MAX)) held_nxt = DUTY_MAX;
            else held_nxt = duty[14:0];
            wr_nxt = 1'b1;
          end
          prev_nxt = err_r;
          accum_nxt = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    ms_r <= ms_nxt; sum_r <= sum_nxt; filt_r <= filt_nxt; err_r <= err_nxt;
    pid_r <= pid_nxt; acc_r <= acc_nxt; wr_r <= wr_nxt; sum_i_r <= sum_i_nxt;
    part_r <= part_nxt; base_r <= base_nxt; deriv_r <= deriv_nxt;
    dstep_r <= dstep_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE; enc_last_r <= '0; accum_r <= '0; slot_r <= '0;
      integ_r <= '0; prev_r <= '0; held_r <= '0; out_valid_r <= 1'b0;
      for (int i = 0; i < AVERAGE_LENGTH; i++) hist_r[i] <= '0;
    end else begin
      state_r <= state_nxt; enc_last_r <= enc_last_nxt; accum_r <= accum_nxt;
      slot_r <= slot_nxt; integ_r <= integ_nxt; prev_r <= prev_nxt;
      held_r <= held_nxt; out_valid_r <= out_valid_nxt;
      if (hist_we) hist_r[slot_r] <= hist_wd;
    end
  end

  // Result register, loaded as the item leaves the sequencer.
  logic [6:0] o_duty_r;
  logic       o_wr_r;
  logic signed [23:0] o_filt_r, o_err_r, o_pid_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      o_duty_r <= held_r[14:8]; o_wr_r <= wr_r;
      o_filt_r <= filt_r; o_err_r <= err_r; o_pid_r <= pid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_duty_percent = o_duty_r;
  assign out_duty_written = o_wr_r;
  assign out_filtered_speed = o_filt_r;
  assign out_speed_error = o_err_r;
  assign out_pid_output = o_pid_r;
endmodule
